// ===== sv/ahn_pkg.sv =====
// ----------------------------------------------------------------------------
// ahn_pkg
// Shared constants, types and name tables for the accept header negotiator.
// ----------------------------------------------------------------------------
package ahn_pkg;

  // result codes on media_type
  typedef enum logic [1:0] {
    MT_NONE = 2'd0,
    MT_JSON = 2'd1,
    MT_LD   = 2'd2,
    MT_GEO  = 2'd3
  } media_e;

  // slots of the per-type best tables
  localparam logic [1:0] T_JSON = 2'd0;
  localparam logic [1:0] T_LD   = 2'd1;
  localparam logic [1:0] T_GEO  = 2'd2;

  // q weights in thousandths
  localparam logic [10:0] Q_ONE = 11'd1000;

  // candidate names, padded to the longest one
  localparam int NAME_COUNT = 5;
  localparam int NAME_CHARS = 20;
  localparam logic [8*NAME_CHARS-1:0] CAND_NAME [NAME_COUNT] = '{
    "application/geo+json",
    "application/ld+json ",
    "application/json    ",
    "application/*       ",
    "*/*                 "
  };
  localparam logic [4:0] CAND_LEN [NAME_COUNT] = '{5'd20, 5'd19, 5'd16, 5'd13, 5'd3};

  // characters that steer the parser
  localparam logic [7:0] CH_COMMA = 8'h2c;
  localparam logic [7:0] CH_SEMI  = 8'h3b;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_EQ    = 8'h3d;
  localparam logic [7:0] CH_LQ    = 8'h71;
  localparam logic [7:0] CH_UQ    = 8'h51;
  localparam logic [7:0] CH_MINUS = 8'h2d;
  localparam logic [7:0] CH_PLUS  = 8'h2b;
  localparam logic [7:0] CH_DOT   = 8'h2e;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_UA    = 8'h41;
  localparam logic [7:0] CH_UZ    = 8'h5a;

  // flags of the q value parse
  typedef struct packed {
    logic stop;
    logic dot;
    logic neg;
  } q_flags_t;

  // character of candidate k at position pos (pos below the name length)
  function automatic logic [7:0] cand_char(input int k, input logic [4:0] pos);
    logic [4:0] p;
    logic [7:0] base;
    p = (pos < 5'(NAME_CHARS)) ? pos : 5'd0;
    base = 8'(8 * NAME_CHARS - 1) - {p, 3'b000};
    return CAND_NAME[k][base -: 8];
  endfunction

  // one fraction digit scaled by its place
  function automatic logic [9:0] frac_term(input logic [3:0] d, input logic [1:0] place);
    logic [9:0] r;
    case (place)
      2'd0:    r = 10'(d) * 10'd100;
      2'd1:    r = 10'(d) * 10'd10;
      default: r = 10'(d);
    endcase
    return r;
  endfunction

endpackage

// ===== sv/accept_header_negotiator_core.sv =====
// ----------------------------------------------------------------------------
// accept_header_negotiator_core
// Parses an Accept header one byte per word and, on the end word, gives the
// preferred of json, ld+json and geo+json, or none when none of them is acceptable.
// ----------------------------------------------------------------------------
// result: the result of an end word is on the output in the cycle after it is taken
// throughput: one word per cycle while the input is not stalled, header bytes and end words alike
// the parser state updates in the accepting cycle; a result register holds the answer
// input stalls only while a result waits and the output side stalls
// reset (asynchronous, active low) clears the parser, the best tables and the result
module accept_header_negotiator_core
  import ahn_pkg::*;
#(
  parameter int MAX_ENTRIES = 64,
  parameter int Q_CHARS     = 15
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic       command_i,
  input  logic [7:0] header_byte_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [1:0] media_type_o
);

  localparam int EW  = (MAX_ENTRIES > 2) ? $clog2(MAX_ENTRIES) : 1;
  localparam int QCW = $clog2(Q_CHARS + 1);

  typedef enum logic [2:0] {
    PH_LEAD  = 3'd0,
    PH_NAME  = 3'd1,
    PH_PSEP  = 3'd2,
    PH_PSKIP = 3'd3,
    PH_Q1    = 3'd4,
    PH_Q2    = 3'd5,
    PH_QVAL  = 3'd6,
    PH_DONE  = 3'd7
  } phase_e;

  phase_e            phase_q, phase_d;
  logic [4:0]        name_pos_q, name_pos_d;
  logic [4:0]        name_alive_q, name_alive_d;
  logic [10:0]       q_acc_q, q_acc_d;
  logic [1:0]        q_fd_q, q_fd_d;
  logic [QCW-1:0]    q_cnt_q, q_cnt_d;
  q_flags_t          q_flags_q, q_flags_d;
  logic [10:0]       best_q_q [3];
  logic [10:0]       best_q_d [3];
  logic [2:0]        best_seen_q, best_seen_d;
  logic [EW-1:0]     best_order_q [3];
  logic [EW-1:0]     best_order_d [3];
  logic [EW-1:0]     entry_idx_q, entry_idx_d;
  logic              any_seen_q, any_seen_d;
  logic              out_valid_q, out_valid_d;
  media_e            media_q, media_d;

  logic              accept;
  logic [7:0]        c;
  logic [7:0]        lc;
  logic              is_ws;
  logic              is_digit;
  logic [3:0]        digit;

  // handshake: the only reason to stall is a held, stalled result
  assign in_stall_o   = out_valid_q & out_stall_i;
  assign accept       = in_valid_i & ~in_stall_o;
  assign out_valid_o  = out_valid_q;
  assign media_type_o = media_q;

  // character classes
  assign c        = header_byte_i;
  assign lc       = (c >= CH_UA && c <= CH_UZ) ? c + 8'd32 : c;
  assign is_ws    = (c == CH_SPACE) || (c == CH_TAB);
  assign is_digit = (c >= CH_ZERO) && (c <= CH_NINE);
  assign digit    = 4'(c - CH_ZERO);

  // name matcher step
  logic [4:0] alive_step;
  logic [4:0] pos_step;
  always_comb begin
    for (int k = 0; k < NAME_COUNT; k++) begin
      alive_step[k] = name_alive_q[k] && (name_pos_q < CAND_LEN[k]) &&
                      (lc == cand_char(k, name_pos_q));
    end
    pos_step = (name_pos_q < 5'd31) ? name_pos_q + 5'd1 : name_pos_q;
  end

  // q value finish on the current state
  logic [10:0] q_fin_cur;
  always_comb begin
    if (q_flags_q.neg) begin
      q_fin_cur = 11'd0;
    end else if (q_acc_q > Q_ONE) begin
      q_fin_cur = Q_ONE;
    end else begin
      q_fin_cur = q_acc_q;
    end
  end

  // q value character step
  logic [10:0]    qs_acc;
  logic [1:0]     qs_fd;
  logic [QCW-1:0] qs_cnt;
  q_flags_t       qs_flags;
  logic           qs_finish;
  logic [10:0]    qs_fin;
  always_comb begin
    qs_acc   = q_acc_q;
    qs_fd    = q_fd_q;
    qs_flags = q_flags_q;
    qs_cnt   = q_cnt_q + QCW'(1);
    if (!q_flags_q.stop) begin
      if (q_cnt_q == '0 && c == CH_MINUS) begin
        qs_flags.neg = 1'b1;
      end else if (q_cnt_q == '0 && c == CH_PLUS) begin
        qs_flags.neg = q_flags_q.neg;
      end else if (is_digit) begin
        if (q_flags_q.dot) begin
          if (q_fd_q != 2'd3) begin
            qs_acc = q_acc_q + 11'(frac_term(digit, q_fd_q));
            qs_fd  = q_fd_q + 2'd1;
          end
        end else if (q_acc_q != 11'd0 || digit != 4'd0) begin
          qs_acc = Q_ONE;
        end
      end else if (c == CH_DOT && !q_flags_q.dot) begin
        qs_flags.dot = 1'b1;
      end else begin
        qs_flags.stop = 1'b1;
      end
    end
    qs_finish = (qs_cnt >= QCW'(Q_CHARS));
    if (qs_flags.neg) begin
      qs_fin = 11'd0;
    end else if (qs_acc > Q_ONE) begin
      qs_fin = Q_ONE;
    end else begin
      qs_fin = qs_acc;
    end
  end

  // entry close: weight, matched type and updated best tables
  logic [10:0]   close_q;
  logic          close_hit;
  logic [1:0]    close_t;
  logic [10:0]   bc_q [3];
  logic [2:0]    bc_seen;
  logic [EW-1:0] bc_order [3];
  logic [EW-1:0] entry_next;
  always_comb begin
    if (phase_q == PH_QVAL) begin
      close_q = q_fin_cur;
    end else if (phase_q == PH_DONE) begin
      close_q = q_acc_q;
    end else begin
      close_q = Q_ONE;
    end
    close_hit = 1'b0;
    close_t   = T_JSON;
    for (int k = NAME_COUNT - 1; k >= 0; k--) begin
      if (name_alive_q[k] && name_pos_q == CAND_LEN[k]) begin
        close_hit = 1'b1;
        close_t   = (k == 0) ? T_GEO : (k == 1) ? T_LD : T_JSON;
      end
    end
    bc_q     = best_q_q;
    bc_seen  = best_seen_q;
    bc_order = best_order_q;
    if (close_hit && (!best_seen_q[close_t] || close_q > best_q_q[close_t])) begin
      bc_seen[close_t]  = 1'b1;
      bc_q[close_t]     = close_q;
      bc_order[close_t] = entry_idx_q;
    end
    entry_next = (entry_idx_q < EW'(MAX_ENTRIES - 1)) ? entry_idx_q + EW'(1) : entry_idx_q;
  end

  // decision over the tables as they stand after the last close
  logic          do_close;
  logic [10:0]   dq [3];
  logic [2:0]    dv;
  logic [EW-1:0] dord [3];
  logic          ld_wins;
  logic          cur_valid;
  logic [10:0]   cur_q;
  logic [EW-1:0] cur_o;
  logic          geo_wins;
  media_e        decision;
  always_comb begin
    do_close = any_seen_q && (phase_q != PH_LEAD);
    for (int t = 0; t < 3; t++) begin
      dq[t]   = do_close ? bc_q[t] : best_q_q[t];
      dord[t] = do_close ? bc_order[t] : best_order_q[t];
      dv[t]   = (do_close ? bc_seen[t] : best_seen_q[t]) && (dq[t] != 11'd0);
    end
    ld_wins = dv[T_LD] && (!dv[T_JSON] || dq[T_LD] > dq[T_JSON] ||
              (dq[T_LD] == dq[T_JSON] && dord[T_LD] < dord[T_JSON]));
    cur_valid = dv[T_JSON] || ld_wins;
    cur_q     = ld_wins ? dq[T_LD] : dq[T_JSON];
    cur_o     = ld_wins ? dord[T_LD] : dord[T_JSON];
    geo_wins = dv[T_GEO] && (!cur_valid || dq[T_GEO] > cur_q ||
               (dq[T_GEO] == cur_q && dord[T_GEO] < cur_o));
    if (!any_seen_q) begin
      decision = MT_JSON;
    end else if (dv == 3'b000) begin
      decision = MT_NONE;
    end else if (geo_wins) begin
      decision = MT_GEO;
    end else if (ld_wins) begin
      decision = MT_LD;
    end else begin
      decision = MT_JSON;
    end
  end

  // next state for one accepted word
  always_comb begin
    phase_d      = phase_q;
    name_pos_d   = name_pos_q;
    name_alive_d = name_alive_q;
    q_acc_d      = q_acc_q;
    q_fd_d       = q_fd_q;
    q_cnt_d      = q_cnt_q;
    q_flags_d    = q_flags_q;
    best_q_d     = best_q_q;
    best_seen_d  = best_seen_q;
    best_order_d = best_order_q;
    entry_idx_d  = entry_idx_q;
    any_seen_d   = any_seen_q;
    out_valid_d  = out_valid_q & out_stall_i;
    media_d      = media_q;

    if (accept) begin
      if (command_i) begin
        // end word: give the result and start over
        out_valid_d  = 1'b1;
        media_d      = decision;
        phase_d      = PH_LEAD;
        name_pos_d   = 5'd0;
        name_alive_d = 5'h1f;
        q_acc_d      = 11'd0;
        q_fd_d       = 2'd0;
        q_cnt_d      = '0;
        q_flags_d    = '0;
        for (int t = 0; t < 3; t++) begin
          best_q_d[t]     = 11'd0;
          best_order_d[t] = '0;
        end
        best_seen_d  = 3'b000;
        entry_idx_d  = '0;
        any_seen_d   = 1'b0;
      end else if (c == CH_COMMA) begin
        // entry separator
        any_seen_d   = 1'b1;
        best_q_d     = bc_q;
        best_seen_d  = bc_seen;
        best_order_d = bc_order;
        entry_idx_d  = entry_next;
        phase_d      = PH_LEAD;
        name_pos_d   = 5'd0;
        name_alive_d = 5'h1f;
        q_acc_d      = 11'd0;
        q_fd_d       = 2'd0;
        q_cnt_d      = '0;
        q_flags_d    = '0;
      end else begin
        any_seen_d = 1'b1;
        unique case (phase_q)
          PH_LEAD: begin
            if (c == CH_SEMI) begin
              phase_d = PH_PSEP;
            end else if (!is_ws) begin
              phase_d      = PH_NAME;
              name_alive_d = alive_step;
              name_pos_d   = pos_step;
            end
          end
          PH_NAME: begin
            if (is_ws || c == CH_SEMI) begin
              phase_d = PH_PSEP;
            end else begin
              name_alive_d = alive_step;
              name_pos_d   = pos_step;
            end
          end
          PH_PSEP: begin
            if (!(is_ws || c == CH_SEMI)) begin
              phase_d = (c == CH_LQ || c == CH_UQ) ? PH_Q1 : PH_PSKIP;
            end
          end
          PH_PSKIP: begin
            if (c == CH_SEMI) begin
              phase_d = PH_PSEP;
            end
          end
          PH_Q1: begin
            if (c == CH_EQ) begin
              phase_d = PH_Q2;
            end else begin
              phase_d = (c == CH_SEMI) ? PH_PSEP : PH_PSKIP;
            end
          end
          PH_Q2, PH_QVAL: begin
            if (is_ws || c == CH_SEMI) begin
              q_acc_d   = q_fin_cur;
              q_flags_d = '0;
              phase_d   = PH_DONE;
            end else if (qs_finish) begin
              q_acc_d   = qs_fin;
              q_fd_d    = qs_fd;
              q_cnt_d   = qs_cnt;
              q_flags_d = '0;
              phase_d   = PH_DONE;
            end else begin
              q_acc_d   = qs_acc;
              q_fd_d    = qs_fd;
              q_cnt_d   = qs_cnt;
              q_flags_d = qs_flags;
              phase_d   = PH_QVAL;
            end
          end
          PH_DONE: begin
            phase_d = PH_DONE;
          end
          default: begin
            phase_d = PH_LEAD;
          end
        endcase
      end
    end
  end

  // state and result registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PH_LEAD;
      name_pos_q   <= 5'd0;
      name_alive_q <= 5'h1f;
      q_acc_q      <= 11'd0;
      q_fd_q       <= 2'd0;
      q_cnt_q      <= '0;
      q_flags_q    <= '0;
      for (int t = 0; t < 3; t++) begin
        best_q_q[t]     <= 11'd0;
        best_order_q[t] <= '0;
      end
      best_seen_q  <= 3'b000;
      entry_idx_q  <= '0;
      any_seen_q   <= 1'b0;
      out_valid_q  <= 1'b0;
      media_q      <= MT_NONE;
    end else begin
      phase_q      <= phase_d;
      name_pos_q   <= name_pos_d;
      name_alive_q <= name_alive_d;
      q_acc_q      <= q_acc_d;
      q_fd_q       <= q_fd_d;
      q_cnt_q      <= q_cnt_d;
      q_flags_q    <= q_flags_d;
      best_q_q     <= best_q_d;
      best_seen_q  <= best_seen_d;
      best_order_q <= best_order_d;
      entry_idx_q  <= entry_idx_d;
      any_seen_q   <= any_seen_d;
      out_valid_q  <= out_valid_d;
      media_q      <= media_d;
    end
  end

  // an accepted end word always leaves a result behind
  a_end_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && command_i |=> out_valid_q)
    else $error("end word produced no result");

  // an end word returns the parser to its initial state
  a_end_restarts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && command_i |=> phase_q == PH_LEAD && entry_idx_q == '0 && !any_seen_q
                            && best_seen_q == 3'b000)
    else $error("parser not restarted after end word");

  // stall only while a result is held
  a_stall_needs_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_q)
    else $error("input stalled with no result held");

  // a finished q value is always clamped
  a_q_clamped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_DONE |-> q_acc_q <= Q_ONE)
    else $error("finished q above one");

  // a type never seen keeps a zero weight
  a_unseen_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (best_seen_q[0] || best_q_q[0] == 11'd0) &&
    (best_seen_q[1] || best_q_q[1] == 11'd0) &&
    (best_seen_q[2] || best_q_q[2] == 11'd0))
    else $error("weight recorded for an unseen type");

endmodule
